### rtl/tms_pkg.sv
package tms_pkg;

   // Sizing
   localparam int SONG_BYTES        = 65536;
   localparam int VOICES            = 4;
   localparam int MAX_CMDS_PER_TICK = 256;

   localparam int MEM_AW   = $clog2(SONG_BYTES);
   localparam int VOICE_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int HB_COUNT = 4 + VOICES;
   localparam int HB_W     = $clog2(HB_COUNT);
   localparam int BUDGET_W = $clog2(MAX_CMDS_PER_TICK + 1);

   // Header base slots
   localparam int HB_SUB = 0;
   localparam int HB_VOL = 1;
   localparam int HB_PER = 2;
   localparam int HB_CHN = 3;
   localparam int HB_BLK = 3 + VOICES;

   // Request actions
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_REPEAT_COUNT     = 2'd0;
   localparam logic [1:0] CSR_INSTRUMENT_COUNT = 2'd1;
   localparam logic [1:0] CSR_SONG_LENGTH      = 2'd2;

   // Command byte codes
   localparam logic [7:0] END_MARK     = 8'hFF;
   localparam logic [7:0] CMD_GROUP    = 8'hE0;
   localparam logic [7:0] CMD_TICKS    = 8'h80;
   localparam logic [7:0] CMD_SAMPLE   = 8'hA0;
   localparam logic [7:0] CMD_VOLSLIDE = 8'hC0;
   localparam logic [4:0] EXT_PERMOD   = 5'd0;
   localparam logic [4:0] EXT_PSLIDE_A = 5'd1;
   localparam logic [4:0] EXT_PSLIDE_B = 5'd2;
   localparam logic [7:0] SLIDE_STRIDE = 8'd13;
   localparam logic [7:0] NO_SAMPLE    = 8'hFF;

   localparam int PERIOD_ENTRIES = 169;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] address;
      logic [7:0]  song_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  channel;
      logic [14:0] volume;
      logic [14:0] period;
      logic        sample_load;
      logic [4:0]  sample_index;
      logic        song_ended;
      logic        header_error;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] base;
      logic [7:0]  amount;
      logic [7:0]  offset;
      logic [15:0] fine_up;
      logic [15:0] fine_down;
      logic [7:0]  delay_a;
      logic [7:0]  delay_b;
      logic        f_sign;   // flag 0x80
      logic        f_hold;   // flag 0x04
      logic        f_step;   // flag 0x01
   } slide_type;

   localparam logic [15:0] PERIOD_TAB [PERIOD_ENTRIES] = '{
      16'h6ACC, 16'h64CC, 16'h5F25, 16'h59CE, 16'h54C3, 16'h5003, 16'h4B86, 16'h4747,
      16'h4346, 16'h3F8B, 16'h3BF3, 16'h3892, 16'h3568, 16'h3269, 16'h2F93, 16'h2CEA,
      16'h2A66, 16'h2801, 16'h2566, 16'h23A5, 16'h21AF, 16'h1FC4, 16'h1DFE, 16'h1C4E,
      16'h1ABC, 16'h1936, 16'h17CC, 16'h1676, 16'h1533, 16'h1401, 16'h12E4, 16'h11D5,
      16'h10D4, 16'h0FE3, 16'h0EFE, 16'h0E26, 16'h0D5B, 16'h0C9B, 16'h0BE5, 16'h0B3B,
      16'h0A9B, 16'h0A02, 16'h0972, 16'h08E9, 16'h0869, 16'h07F1, 16'h077F, 16'h0713,
      16'h06AD, 16'h064D, 16'h05F2, 16'h059D, 16'h054D, 16'h0500, 16'h04B8, 16'h0475,
      16'h0435, 16'h03F8, 16'h03BF, 16'h038A, 16'h0356, 16'h0326, 16'h02F9, 16'h02CF,
      16'h02A6, 16'h0280, 16'h025C, 16'h023A, 16'h021A, 16'h01FC, 16'h01E0, 16'h01C5,
      16'h01AB, 16'h0193, 16'h017D, 16'h0167, 16'h0153, 16'h0140, 16'h012E, 16'h011D,
      16'h010D, 16'h00FE, 16'h00F0, 16'h00E2, 16'h00D6, 16'h00CA, 16'h00BE, 16'h00B4,
      16'h00AA, 16'h00A0, 16'h0097, 16'h008F, 16'h0087, 16'h007F, 16'h0078, 16'h0070,
      16'h0060, 16'h0050, 16'h0040, 16'h0030, 16'h0020, 16'h0010, 16'h0000, 16'h0000,
      16'h0020, 16'h2020, 16'h2020, 16'h2020, 16'h2020, 16'h3030, 16'h3030, 16'h3020,
      16'h2020, 16'h2020, 16'h2020, 16'h2020, 16'h2020, 16'h2020, 16'h2020, 16'h2020,
      16'h2090, 16'h4040, 16'h4040, 16'h4040, 16'h4040, 16'h4040, 16'h4040, 16'h4040,
      16'h400C, 16'h0C0C, 16'h0C0C, 16'h0C0C, 16'h0C0C, 16'h0C40, 16'h4040, 16'h4040,
      16'h4040, 16'h0909, 16'h0909, 16'h0909, 16'h0101, 16'h0101, 16'h0101, 16'h0101,
      16'h0101, 16'h0101, 16'h0101, 16'h0101, 16'h0101, 16'h0101, 16'h4040, 16'h4040,
      16'h4040, 16'h0A0A, 16'h0A0A, 16'h0A0A, 16'h0202, 16'h0202, 16'h0202, 16'h0202,
      16'h0202, 16'h0202, 16'h0202, 16'h0202, 16'h0202, 16'h0202, 16'h4040, 16'h4040,
      16'h2000
   };

   // Note index to period; outside the table gives zero
   function automatic logic [15:0] note_period_of(input logic signed [9:0] idx);
      logic [15:0] p;
      p = '0;
      if (idx >= 0 && idx < 10'(PERIOD_ENTRIES)) begin
         p = PERIOD_TAB[8'(idx)];
      end
      return p;
   endfunction

   // Tick length by index; above eleven uses the longest
   function automatic logic [7:0] tick_len_of(input logic [3:0] i);
      logic [7:0] t;
      case (i)
         4'd0:    t = 8'd2;
         4'd1:    t = 8'd3;
         4'd2:    t = 8'd4;
         4'd3:    t = 8'd6;
         4'd4:    t = 8'd8;
         4'd5:    t = 8'd12;
         4'd6:    t = 8'd16;
         4'd7:    t = 8'd24;
         4'd8:    t = 8'd32;
         4'd9:    t = 8'd48;
         4'd10:   t = 8'd64;
         default: t = 8'd96;
      endcase
      return t;
   endfunction

endpackage

### rtl/tms_ram.sv
module tms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write or read one entry, read data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

### rtl/tracker_music_sequencer.sv
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | req_type: action, address, song_byte
// rsp     | out       | rsp_valid/rsp_stall | rsp_type: one result per voice or start
// csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
// A write goes straight to the song memory. A start reads the header byte by byte.
// A tick walks each voice through the song memory one byte read at a time, over block entries,
// command bytes and slide pairs, then gives one result per voice as rsp_stall allows.
// Reset is synchronous and leaves playback stopped. A new request is taken while the last
// result still waits on rsp_stall; the result register holds until it is taken.
module tracker_music_sequencer import tms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_H_SUBHI, S_H_SUBLO, S_H_HI, S_H_LO, S_H_DONE,
      S_V_START, S_B_RD, S_B_CHK, S_B_HI, S_B_LO, S_C_RD, S_C_CHK, S_C_VOL, S_C_ARG,
      S_SL0, S_SL1, S_SL2, S_SL3, S_SL4, S_V_END, S_T_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic signed [8:0] repeat_count_ff, repeat_count_in;
   logic [5:0]        instr_count_ff, instr_count_in;
   logic [16:0]       song_length_ff, song_length_in;

   // Song state
   logic [15:0]       hb_ff [HB_COUNT];
   logic [15:0]       hb_in [HB_COUNT];
   logic [15:0]       speed_reload_ff, speed_reload_in;
   logic [15:0]       speed_count_ff, speed_count_in;
   logic signed [8:0] repeats_left_ff, repeats_left_in;
   logic [7:0]        pending_ff, pending_in;
   logic              stopped_ff, stopped_in;

   // Voice state
   logic [15:0]       tp_ff [VOICES];
   logic [15:0]       tp_in [VOICES];
   logic [15:0]       cp_ff [VOICES];
   logic [15:0]       cp_in [VOICES];
   logic [VOICES-1:0] restart_ff, restart_in;
   logic [VOICES-1:0] done_ff, done_in;
   logic [7:0]        tick_left_ff [VOICES];
   logic [7:0]        tick_left_in [VOICES];
   logic [7:0]        tick_reload_ff [VOICES];
   logic [7:0]        tick_reload_in [VOICES];
   logic [15:0]       note_ff [VOICES];
   logic [15:0]       note_in [VOICES];
   logic [7:0]        poff_ff [VOICES];
   logic [7:0]        poff_in [VOICES];
   slide_type         sl_ff [VOICES][2];
   slide_type         sl_in [VOICES][2];

   // Tick results, held until the end of the tick
   logic [14:0]       res_vol_ff [VOICES];
   logic [14:0]       res_vol_in [VOICES];
   logic [14:0]       res_per_ff [VOICES];
   logic [14:0]       res_per_in [VOICES];
   logic              res_load_ff [VOICES];
   logic              res_load_in [VOICES];
   logic [4:0]        res_idx_ff [VOICES];
   logic [4:0]        res_idx_in [VOICES];

   // Walk registers
   logic [VOICE_W-1:0]  voice_ff, voice_in;
   logic                sel_ff, sel_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [7:0]          hi_ff, hi_in;
   logic [7:0]          blk_ff, blk_in;
   logic [7:0]          cmd_ff, cmd_in;
   logic [15:0]         paddr_ff, paddr_in;
   logic [15:0]         sub_ff, sub_in;
   logic [HB_W-1:0]     hidx_ff, hidx_in;
   logic                err_ff, err_in;
   logic [14:0]         cur_vol_ff, cur_vol_in;
   logic [14:0]         cur_per_ff, cur_per_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Memory port
   logic              ram_we;
   logic [15:0]       ram_addr;
   logic [7:0]        ram_rdata;

   logic              req_take;
   logic              out_free;
   logic              last_voice;
   slide_type         cur_sl;
   logic [15:0]       sl_d;
   logic [15:0]       hdr_addr;

   tms_ram #(.WIDTH(8), .DEPTH(SONG_BYTES)) u_song_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr[MEM_AW-1:0]),
      .wdata (req_data.song_byte),
      .rdata (ram_rdata)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign ram_we     = req_take && (req_data.action == ACT_WRITE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_voice = (voice_ff == VOICE_W'(VOICES - 1));
   assign cur_sl     = sl_ff[voice_ff][sel_ff];
   assign sl_d       = cur_sl.base + 16'(cur_sl.offset);
   assign hdr_addr   = sub_ff + 16'({hidx_ff, 1'b0});
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      logic              do_restart;
      logic [7:0]        tl;
      logic [16:0]       sum;
      logic signed [18:0] sv;
      logic [15:0]       start_v;
      logic [7:0]        off;
      logic [15:0]       word;
      logic [15:0]       note_p;
      logic              all_done;

      do_restart = 1'b0;
      tl         = '0;
      sum        = '0;
      sv         = '0;
      start_v    = '0;
      off        = '0;
      word       = '0;
      note_p     = '0;
      all_done   = &done_ff;

      state_in        = state_ff;
      repeat_count_in = repeat_count_ff;
      instr_count_in  = instr_count_ff;
      song_length_in  = song_length_ff;
      hb_in           = hb_ff;
      speed_reload_in = speed_reload_ff;
      speed_count_in  = speed_count_ff;
      repeats_left_in = repeats_left_ff;
      pending_in      = pending_ff;
      stopped_in      = stopped_ff;
      tp_in           = tp_ff;
      cp_in           = cp_ff;
      restart_in      = restart_ff;
      done_in         = done_ff;
      tick_left_in    = tick_left_ff;
      tick_reload_in  = tick_reload_ff;
      note_in         = note_ff;
      poff_in         = poff_ff;
      sl_in           = sl_ff;
      res_vol_in      = res_vol_ff;
      res_per_in      = res_per_ff;
      res_load_in     = res_load_ff;
      res_idx_in      = res_idx_ff;
      voice_in        = voice_ff;
      sel_in          = sel_ff;
      budget_in       = budget_ff;
      hi_in           = hi_ff;
      blk_in          = blk_ff;
      cmd_in          = cmd_ff;
      paddr_in        = paddr_ff;
      sub_in          = sub_ff;
      hidx_in         = hidx_ff;
      err_in          = err_ff;
      cur_vol_in      = cur_vol_ff;
      cur_per_in      = cur_per_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      ram_addr        = req_data.address;

      // Register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_REPEAT_COUNT:     repeat_count_in = $signed(csr_wdata[8:0]);
            CSR_INSTRUMENT_COUNT: instr_count_in  = csr_wdata[5:0];
            CSR_SONG_LENGTH:      song_length_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_data.action)
                  ACT_START: begin
                     ram_addr = '0;
                     state_in = S_H_SUBHI;
                  end
                  ACT_TICK: begin
                     voice_in = '0;
                     if (stopped_ff) begin
                        // Stopped: silent results for every voice
                        for (int v = 0; v < VOICES; v++) begin
                           res_vol_in[v]  = '0;
                           res_per_in[v]  = '0;
                           res_load_in[v] = 1'b0;
                           res_idx_in[v]  = '0;
                        end
                        state_in = S_OUT;
                     end else begin
                        speed_count_in = speed_count_ff - 16'd1;
                        pending_in     = NO_SAMPLE;
                        state_in       = S_V_START;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Header parse
         S_H_SUBHI: begin
            hi_in    = ram_rdata;
            ram_addr = 16'd1;
            state_in = S_H_SUBLO;
         end
         S_H_SUBLO: begin
            word   = {hi_ff, ram_rdata};
            sub_in = word;
            sum    = {1'b0, word} + 17'(8 + 2 * VOICES);
            err_in = (song_length_ff < 17'd20) || ({1'b0, word} > song_length_ff)
                     || (sum > song_length_ff);
            hb_in[HB_SUB] = word;
            hb_in[HB_BLK] = sum[15:0];
            hidx_in  = '0;
            ram_addr = word;
            state_in = S_H_HI;
         end
         S_H_HI: begin
            hi_in    = ram_rdata;
            ram_addr = hdr_addr + 16'd1;
            state_in = S_H_LO;
         end
         S_H_LO: begin
            word = {hi_ff, ram_rdata};
            sum  = {1'b0, sub_ff} + {1'b0, word};
            if (hidx_ff == '0) begin
               speed_reload_in = word;
            end else begin
               hb_in[hidx_ff] = sum[15:0];
               if (sum > song_length_ff) begin
                  err_in = 1'b1;
               end
            end
            if (hidx_ff == HB_W'(2 + VOICES)) begin
               state_in = S_H_DONE;
            end else begin
               hidx_in  = hidx_ff + 1'b1;
               ram_addr = hdr_addr + 16'd2;
               state_in = S_H_HI;
            end
         end
         S_H_DONE: begin
            if (out_free) begin
               repeats_left_in = repeat_count_ff;
               pending_in      = NO_SAMPLE;
               stopped_in      = err_ff;
               do_restart      = 1'b1;
               rsp_in          = '0;
               rsp_in.song_ended   = err_ff;
               rsp_in.header_error = err_ff;
               rsp_in.last         = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end

         // Voice entry
         S_V_START: begin
            budget_in = '0;
            sel_in    = 1'b0;
            if (done_ff[voice_ff]) begin
               cur_vol_in = '0;
               cur_per_in = '0;
               state_in   = S_V_END;
            end else if (restart_ff[voice_ff]) begin
               restart_in[voice_ff] = 1'b0;
               tp_in[voice_ff]      = hb_ff[HB_CHN + int'(voice_ff)];
               state_in             = S_B_RD;
            end else begin
               tl = tick_left_ff[voice_ff] - ((speed_count_ff == '0) ? 8'd1 : 8'd0);
               if (tl != '0) begin
                  tick_left_in[voice_ff] = tl;
                  state_in = S_SL0;
               end else begin
                  tick_left_in[voice_ff] = tick_reload_ff[voice_ff];
                  state_in = S_C_RD;
               end
            end
         end

         // Block list walk
         S_B_RD: begin
            if (budget_ff == BUDGET_W'(MAX_CMDS_PER_TICK)) begin
               done_in[voice_ff] = 1'b1;
               cur_vol_in = '0;
               cur_per_in = '0;
               state_in   = S_V_END;
            end else begin
               budget_in = budget_ff + 1'b1;
               ram_addr  = tp_ff[voice_ff];
               state_in  = S_B_CHK;
            end
         end
         S_B_CHK: begin
            if (ram_rdata == END_MARK) begin
               done_in[voice_ff] = 1'b1;
               cur_vol_in = '0;
               cur_per_in = '0;
               state_in   = S_V_END;
            end else begin
               tp_in[voice_ff] = tp_ff[voice_ff] + 16'd1;
               blk_in   = ram_rdata;
               ram_addr = hb_ff[HB_BLK] + {7'd0, ram_rdata, 1'b0};
               state_in = S_B_HI;
            end
         end
         S_B_HI: begin
            hi_in    = ram_rdata;
            ram_addr = hb_ff[HB_BLK] + {7'd0, blk_ff, 1'b0} + 16'd1;
            state_in = S_B_LO;
         end
         S_B_LO: begin
            cp_in[voice_ff] = hb_ff[HB_SUB] + {hi_ff, ram_rdata};
            state_in = S_C_RD;
         end

         // Command walk
         S_C_RD: begin
            if (budget_ff == BUDGET_W'(MAX_CMDS_PER_TICK)) begin
               done_in[voice_ff] = 1'b1;
               cur_vol_in = '0;
               cur_per_in = '0;
               state_in   = S_V_END;
            end else begin
               budget_in = budget_ff + 1'b1;
               ram_addr  = cp_ff[voice_ff];
               state_in  = S_C_CHK;
            end
         end
         S_C_CHK: begin
            cmd_in = ram_rdata;
            if (ram_rdata == END_MARK) begin
               state_in = S_B_RD;
            end else begin
               cp_in[voice_ff] = cp_ff[voice_ff] + 16'd1;
               state_in = S_C_RD;
               if (ram_rdata[7]) begin
                  case (ram_rdata & CMD_GROUP)
                     CMD_TICKS: begin
                        tick_left_in[voice_ff]   = tick_len_of(ram_rdata[3:0]);
                        tick_reload_in[voice_ff] = tick_len_of(ram_rdata[3:0]);
                     end
                     CMD_SAMPLE: begin
                        pending_in = {3'd0, ram_rdata[4:0]};
                     end
                     CMD_VOLSLIDE: begin
                        paddr_in = hb_ff[HB_VOL] + 16'(ram_rdata[4:0]) * 16'(SLIDE_STRIDE);
                        ram_addr = hb_ff[HB_VOL] + 16'(ram_rdata[4:0]) * 16'(SLIDE_STRIDE);
                        state_in = S_C_VOL;
                     end
                     default: begin
                        if (ram_rdata[4:0] == EXT_PERMOD || ram_rdata[4:0] == EXT_PSLIDE_A
                            || ram_rdata[4:0] == EXT_PSLIDE_B) begin
                           ram_addr = cp_ff[voice_ff] + 16'd1;
                           state_in = S_C_ARG;
                        end
                     end
                  endcase
               end else begin
                  // Note: new period, rewind both envelopes, then run them
                  note_p = note_period_of($signed({2'd0, ram_rdata})
                           + ((ram_rdata != '0) ? 10'($signed(poff_ff[voice_ff])) : 10'sd0));
                  note_in[voice_ff] = note_p;
                  for (int k = 0; k < 2; k++) begin
                     sl_in[voice_ff][k].offset    = '0;
                     sl_in[voice_ff][k].fine_up   = '0;
                     sl_in[voice_ff][k].fine_down = '0;
                     sl_in[voice_ff][k].delay_a   = '0;
                     sl_in[voice_ff][k].delay_b   = '0;
                     sl_in[voice_ff][k].f_step    = 1'b1;
                     sl_in[voice_ff][k].f_hold    = 1'b0;
                  end
                  state_in = S_SL0;
               end
            end
         end
         S_C_VOL: begin
            sl_in[voice_ff][0].f_sign    = ram_rdata[7];
            sl_in[voice_ff][0].f_hold    = 1'b0;
            sl_in[voice_ff][0].f_step    = 1'b1;
            sl_in[voice_ff][0].amount    = {1'b0, ram_rdata[6:0]};
            sl_in[voice_ff][0].base      = paddr_ff + 16'd1;
            sl_in[voice_ff][0].offset    = '0;
            sl_in[voice_ff][0].fine_up   = '0;
            sl_in[voice_ff][0].fine_down = '0;
            sl_in[voice_ff][0].delay_a   = '0;
            sl_in[voice_ff][0].delay_b   = '0;
            state_in = S_C_RD;
         end
         S_C_ARG: begin
            cp_in[voice_ff] = cp_ff[voice_ff] + 16'd1;
            if (cmd_ff[4:0] == EXT_PERMOD) begin
               poff_in[voice_ff] = ram_rdata;
            end else begin
               sl_in[voice_ff][1].base      = hb_ff[HB_PER]
                                              + 16'(ram_rdata) * 16'(SLIDE_STRIDE)
                                              + 16'd1;
               sl_in[voice_ff][1].amount    = '0;
               sl_in[voice_ff][1].offset    = '0;
               sl_in[voice_ff][1].fine_up   = '0;
               sl_in[voice_ff][1].fine_down = '0;
               sl_in[voice_ff][1].delay_a   = '0;
               sl_in[voice_ff][1].delay_b   = '0;
               sl_in[voice_ff][1].f_sign    = (cmd_ff[4:0] == EXT_PSLIDE_A);
               sl_in[voice_ff][1].f_hold    = 1'b0;
               sl_in[voice_ff][1].f_step    = 1'b1;
            end
            state_in = S_C_RD;
         end

         // Slide envelope: volume first, then period
         S_SL0: begin
            if (cur_sl.f_step) begin
               ram_addr = sl_d + 16'd1;
               state_in = S_SL1;
            end else begin
               state_in = S_SL2;
            end
         end
         S_SL1: begin
            sl_in[voice_ff][sel_ff].fine_up = cur_sl.fine_up + {{8{ram_rdata[7]}}, ram_rdata};
            state_in = S_SL2;
         end
         S_SL2: begin
            start_v = sel_ff ? note_ff[voice_ff] : 16'd0;
            sv = $signed({3'd0, start_v}) + 19'($signed(cur_sl.fine_up))
                 - 19'($signed(cur_sl.fine_down));
            if (sv < 0) begin
               sv = '0;
            end else if (sv > 19'sd32767) begin
               sv = 19'sd32767;
            end
            if (sel_ff) begin
               cur_per_in = sv[14:0];
            end else begin
               cur_vol_in = sv[14:0];
            end
            sl_in[voice_ff][sel_ff].f_step = 1'b0;
            if (cur_sl.f_hold) begin
               sel_in   = 1'b1;
               state_in = sel_ff ? S_V_END : S_SL0;
            end else begin
               sl_in[voice_ff][sel_ff].delay_a = cur_sl.delay_a + 8'd1;
               ram_addr = sl_d + 16'd2;
               state_in = S_SL3;
            end
         end
         S_SL3: begin
            if (cur_sl.delay_a != ram_rdata) begin
               sel_in   = 1'b1;
               state_in = sel_ff ? S_V_END : S_SL0;
            end else begin
               sl_in[voice_ff][sel_ff].delay_b = cur_sl.delay_b + 8'd1;
               sl_in[voice_ff][sel_ff].delay_a = '0;
               ram_addr = sl_d;
               state_in = S_SL4;
            end
         end
         S_SL4: begin
            sel_in   = 1'b1;
            state_in = sel_ff ? S_V_END : S_SL0;
            sl_in[voice_ff][sel_ff].f_step = 1'b1;
            if (cur_sl.delay_b == ram_rdata) begin
               off = cur_sl.offset + 8'd3;
               sl_in[voice_ff][sel_ff].delay_b = '0;
               if (off == 8'd12) begin
                  if (!cur_sl.f_sign) begin
                     // End of a one-shot envelope: freeze
                     sl_in[voice_ff][sel_ff].f_hold = 1'b1;
                     sl_in[voice_ff][sel_ff].f_step = 1'b0;
                  end else begin
                     sl_in[voice_ff][sel_ff].fine_down = cur_sl.fine_down
                                                         + 16'(cur_sl.amount);
                     sl_in[voice_ff][sel_ff].offset = 8'd3;
                  end
               end else begin
                  sl_in[voice_ff][sel_ff].offset = off;
               end
            end
         end

         // Store the voice result and take a pending sample
         S_V_END: begin
            res_vol_in[voice_ff]  = cur_vol_ff;
            res_per_in[voice_ff]  = cur_per_ff;
            res_load_in[voice_ff] = 1'b0;
            res_idx_in[voice_ff]  = '0;
            if (pending_ff != NO_SAMPLE && pending_ff < {2'd0, instr_count_ff}) begin
               res_load_in[voice_ff] = 1'b1;
               res_idx_in[voice_ff]  = pending_ff[4:0];
               pending_in = NO_SAMPLE;
            end
            if (last_voice) begin
               state_in = S_T_FIN;
            end else begin
               voice_in = voice_ff + 1'b1;
               state_in = S_V_START;
            end
         end

         // Tick end: speed reload and song end
         S_T_FIN: begin
            if (speed_count_ff == '0) begin
               speed_count_in = speed_reload_ff;
            end
            if (all_done) begin
               if (repeats_left_ff > 0) begin
                  repeats_left_in = repeats_left_ff - 9'sd1;
                  do_restart      = 1'b1;
               end else if (repeats_left_ff != -9'sd1) begin
                  stopped_in = 1'b1;
               end else begin
                  do_restart = 1'b1;
               end
            end
            voice_in = '0;
            state_in = S_OUT;
         end

         S_OUT: begin
            if (out_free) begin
               rsp_in.channel      = 2'(voice_ff);
               rsp_in.volume       = res_vol_ff[voice_ff];
               rsp_in.period       = res_per_ff[voice_ff];
               rsp_in.sample_load  = res_load_ff[voice_ff];
               rsp_in.sample_index = res_idx_ff[voice_ff];
               rsp_in.song_ended   = stopped_ff;
               rsp_in.header_error = 1'b0;
               rsp_in.last         = last_voice;
               rsp_valid_in        = 1'b1;
               if (last_voice) begin
                  state_in = S_IDLE;
               end else begin
                  voice_in = voice_ff + 1'b1;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Restart every voice from the top of its block list
      if (do_restart) begin
         speed_count_in = speed_reload_ff;
         for (int v = 0; v < VOICES; v++) begin
            tp_in[v]          = '0;
            cp_in[v]          = '0;
            sl_in[v][0]       = '0;
            sl_in[v][1]       = '0;
            note_in[v]        = '0;
            restart_in[v]     = 1'b1;
            done_in[v]        = 1'b0;
            tick_left_in[v]   = '0;
            tick_reload_in[v] = '0;
            poff_in[v]        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         repeat_count_ff <= -9'sd1;
         instr_count_ff  <= '0;
         song_length_ff  <= '0;
         repeats_left_ff <= -9'sd1;
         pending_ff      <= NO_SAMPLE;
         stopped_ff      <= 1'b1;
         speed_reload_ff <= '0;
         speed_count_ff  <= '0;
         restart_ff      <= '1;
         done_ff         <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         repeat_count_ff <= repeat_count_in;
         instr_count_ff  <= instr_count_in;
         song_length_ff  <= song_length_in;
         repeats_left_ff <= repeats_left_in;
         pending_ff      <= pending_in;
         stopped_ff      <= stopped_in;
         speed_reload_ff <= speed_reload_in;
         speed_count_ff  <= speed_count_in;
         restart_ff      <= restart_in;
         done_ff         <= done_in;
      end
      hb_ff          <= hb_in;
      tp_ff          <= tp_in;
      cp_ff          <= cp_in;
      tick_left_ff   <= tick_left_in;
      tick_reload_ff <= tick_reload_in;
      note_ff        <= note_in;
      poff_ff        <= poff_in;
      sl_ff          <= sl_in;
      res_vol_ff     <= res_vol_in;
      res_per_ff     <= res_per_in;
      res_load_ff    <= res_load_in;
      res_idx_ff     <= res_idx_in;
      voice_ff       <= voice_in;
      sel_ff         <= sel_in;
      budget_ff      <= budget_in;
      hi_ff          <= hi_in;
      blk_ff         <= blk_in;
      cmd_ff         <= cmd_in;
      paddr_ff       <= paddr_in;
      sub_ff         <= sub_in;
      hidx_ff        <= hidx_in;
      err_ff         <= err_in;
      cur_vol_ff     <= cur_vol_in;
      cur_per_ff     <= cur_per_in;
      rsp_ff         <= rsp_in;
   end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tms_pkg::*;

   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int IMG_BYTES  = 512;
   localparam int CMD_BUDGET = 256;
   localparam int WDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES = 1500;
   localparam int TARGET_ITEMS = 370;

   // Song layout used by the generator (sub block at 2)
   localparam int SUB_AT    = 2;
   localparam int BLKTAB_AT = 18;
   localparam int SLIDES_AT = 28;
   localparam int TRACKS_AT = 132;
   localparam int BLOCKS_AT = 152;
   localparam int EMPTY_AT  = 232;
   localparam int RUNAWAY_AT = 256;

   localparam bit [7:0] TICK_LENGTHS [12] = '{2, 3, 4, 6, 8, 12, 16, 24, 32, 48, 64, 96};
   localparam bit [15:0] NOTE_PERIODS [169] = '{
      16'h6ACC, 16'h64CC, 16'h5F25, 16'h59CE, 16'h54C3, 16'h5003, 16'h4B86, 16'h4747,
      16'h4346, 16'h3F8B, 16'h3BF3, 16'h3892, 16'h3568, 16'h3269, 16'h2F93, 16'h2CEA,
      16'h2A66, 16'h2801, 16'h2566, 16'h23A5, 16'h21AF, 16'h1FC4, 16'h1DFE, 16'h1C4E,
      16'h1ABC, 16'h1936, 16'h17CC, 16'h1676, 16'h1533, 16'h1401, 16'h12E4, 16'h11D5,
      16'h10D4, 16'h0FE3, 16'h0EFE, 16'h0E26, 16'h0D5B, 16'h0C9B, 16'h0BE5, 16'h0B3B,
      16'h0A9B, 16'h0A02, 16'h0972, 16'h08E9, 16'h0869, 16'h07F1, 16'h077F, 16'h0713,
      16'h06AD, 16'h064D, 16'h05F2, 16'h059D, 16'h054D, 16'h0500, 16'h04B8, 16'h0475,
      16'h0435, 16'h03F8, 16'h03BF, 16'h038A, 16'h0356, 16'h0326, 16'h02F9, 16'h02CF,
      16'h02A6, 16'h0280, 16'h025C, 16'h023A, 16'h021A, 16'h01FC, 16'h01E0, 16'h01C5,
      16'h01AB, 16'h0193, 16'h017D, 16'h0167, 16'h0153, 16'h0140, 16'h012E, 16'h011D,
      16'h010D, 16'h00FE, 16'h00F0, 16'h00E2, 16'h00D6, 16'h00CA, 16'h00BE, 16'h00B4,
      16'h00AA, 16'h00A0, 16'h0097, 16'h008F, 16'h0087, 16'h007F, 16'h0078, 16'h0070,
      16'h0060, 16'h0050, 16'h0040, 16'h0030, 16'h0020, 16'h0010, 16'h0000, 16'h0000,
      16'h0020, 16'h2020, 16'h2020, 16'h2020, 16'h2020, 16'h3030, 16'h3030, 16'h3020,
      16'h2020, 16'h2020, 16'h2020, 16'h2020, 16'h2020, 16'h2020, 16'h2020, 16'h2020,
      16'h2090, 16'h4040, 16'h4040, 16'h4040, 16'h4040, 16'h4040, 16'h4040, 16'h4040,
      16'h400C, 16'h0C0C, 16'h0C0C, 16'h0C0C, 16'h0C0C, 16'h0C40, 16'h4040, 16'h4040,
      16'h4040, 16'h0909, 16'h0909, 16'h0909, 16'h0101, 16'h0101, 16'h0101, 16'h0101,
      16'h0101, 16'h0101, 16'h0101, 16'h0101, 16'h0101, 16'h0101, 16'h4040, 16'h4040,
      16'h4040, 16'h0A0A, 16'h0A0A, 16'h0A0A, 16'h0202, 16'h0202, 16'h0202, 16'h0202,
      16'h0202, 16'h0202, 16'h0202, 16'h0202, 16'h0202, 16'h0202, 16'h4040, 16'h4040,
      16'h2000
   };

   typedef struct {
      bit [15:0] base;
      bit [7:0]  amount;
      bit [7:0]  ofs;
      bit [15:0] fine_up;
      bit [15:0] fine_down;
      bit [7:0]  dly_a;
      bit [7:0]  dly_b;
      bit [7:0]  flags;
   } envelope_t;

   // Sequencer predictor and queue of expected voice results
   class sequencer_scoreboard;
      bit [7:0]  mem [65536];
      bit [15:0] hb [8];
      bit [15:0] spd_reload, spd_cnt;
      int        rep_left, rep_cfg;
      int unsigned inst_cfg, len_cfg;
      bit [15:0] trk [4], cptr [4], nper [4];
      bit [7:0]  chflags [4], tleft [4], treload [4], poff [4];
      envelope_t env [4][2];
      bit [7:0]  pend;
      bit        stopped;
      rsp_type   expected [$];

      function new();
         rep_cfg = -1;
         inst_cfg = 0;
         len_cfg = 0;
         spd_reload = 0;
         restart();
         spd_cnt = 0;
         rep_left = -1;
         pend = NO_SAMPLE;
         stopped = 1;
      endfunction

      function int rd(int a);
         return mem[a & 32'hFFFF];
      endfunction

      function int rd16(int a);
         return (rd(a) << 8) | rd(a + 1);
      endfunction

      function int sx8(int v);
         v = v & 255;
         return v[7] ? v - 256 : v;
      endfunction

      function int sx16(int v);
         v = v & 65535;
         return v[15] ? v - 65536 : v;
      endfunction

      function void restart();
         spd_cnt = spd_reload;
         for (int c = 0; c < 4; c++) begin
            trk[c] = 0;
            cptr[c] = 0;
            env[c][0] = '{default: 0};
            env[c][1] = '{default: 0};
            nper[c] = 0;
            chflags[c] = 8'h81;
            tleft[c] = 0;
            treload[c] = 0;
            poff[c] = 0;
         end
      endfunction

      function void rewind(int c, int k);
         env[c][k].ofs = 0;
         env[c][k].fine_up = 0;
         env[c][k].fine_down = 0;
         env[c][k].dly_a = 0;
         env[c][k].dly_b = 0;
      endfunction

      // Advance one slide envelope by a tick and return the clamped level
      function int run_envelope(int c, int k, int start);
         envelope_t s;
         int d, v;
         bit [7:0] nxt;
         bit hold;
         s = env[c][k];
         hold = 0;
         d = s.base + s.ofs;
         if (s.flags[0]) s.fine_up = 16'(int'(s.fine_up) + sx8(rd(d + 1)));
         s.flags[0] = 0;
         v = start + sx16(s.fine_up) - sx16(s.fine_down);
         if (v < 0) v = 0;
         if (v > 32767) v = 32767;
         if (!s.flags[2]) begin
            s.dly_a++;
            if (s.dly_a == rd(d + 2)) begin
               s.dly_b++;
               s.dly_a = 0;
               if (s.dly_b == rd(d)) begin
                  nxt = s.ofs + 8'd3;
                  s.dly_b = 0;
                  if (nxt == 8'd12 && s.flags == 0) begin
                     s.flags[2] = 1;
                     hold = 1;
                  end else begin
                     if (nxt == 8'd12) begin
                        s.fine_down = s.fine_down + s.amount;
                        nxt = 8'd3;
                     end
                     s.ofs = nxt;
                  end
               end
               if (!hold) s.flags[0] = 1;
            end
         end
         env[c][k] = s;
         return v;
      endfunction

      // Walk one voice's commands for a tick
      function void voice_step(int c, output int vol, output int per);
         bit cont;
         int budget, blk, cmd, arg, p, b, idx;
         vol = 0;
         per = 0;
         budget = 0;
         cont = 0;
         if (chflags[c][6]) return;
         if (chflags[c][0]) begin
            chflags[c][0] = 0;
            trk[c] = hb[HB_CHN + c];
         end else begin
            if (spd_cnt == 0) tleft[c]--;
            if (tleft[c] != 0) begin
               vol = run_envelope(c, 0, 0);
               per = run_envelope(c, 1, nper[c]);
               return;
            end
            tleft[c] = treload[c];
            cont = 1;
         end
         while (1) begin
            if (!cont) begin
               budget++;
               if (budget > CMD_BUDGET) begin
                  chflags[c][6] = 1;
                  return;
               end
               blk = rd(trk[c]);
               if (blk == END_MARK) break;
               trk[c]++;
               cptr[c] = 16'(hb[HB_SUB] + rd16(hb[HB_BLK] + blk * 2));
            end
            cont = 0;
            while (1) begin
               budget++;
               if (budget > CMD_BUDGET) begin
                  chflags[c][6] = 1;
                  vol = 0;
                  per = 0;
                  return;
               end
               cmd = rd(cptr[c]);
               if (cmd == END_MARK) break;
               cptr[c]++;
               if (cmd[7]) begin
                  case (8'(cmd) & CMD_GROUP)
                     CMD_TICKS: begin
                        treload[c] = (cmd[3:0] > 11) ? 8'd96 : TICK_LENGTHS[cmd[3:0]];
                        tleft[c] = treload[c];
                     end
                     CMD_SAMPLE: begin
                        pend = cmd & 8'h1F;
                     end
                     CMD_VOLSLIDE: begin
                        p = hb[HB_VOL] + (cmd & 31) * 13;
                        b = rd(p);
                        env[c][0].flags = 8'((b & 8'h80) | 1);
                        env[c][0].amount = 8'(b & 8'h7F);
                        env[c][0].base = 16'(p + 1);
                        rewind(c, 0);
                     end
                     default: begin
                        case (5'(cmd))
                           EXT_PERMOD: begin
                              poff[c] = 8'(rd(cptr[c]));
                              cptr[c]++;
                           end
                           EXT_PSLIDE_A, EXT_PSLIDE_B: begin
                              arg = rd(cptr[c]);
                              cptr[c]++;
                              env[c][1].base = 16'(hb[HB_PER] + arg * 13 + 1);
                              env[c][1].amount = 0;
                              rewind(c, 1);
                              env[c][1].flags = (5'(cmd) == EXT_PSLIDE_A) ? 8'h81 : 8'h01;
                           end
                           default: ;
                        endcase
                     end
                  endcase
               end else begin
                  idx = cmd;
                  if (cmd != 0) idx += sx8(poff[c]);
                  nper[c] = (idx >= 0 && idx < 169) ? NOTE_PERIODS[idx] : 16'd0;
                  rewind(c, 0);
                  env[c][0].flags = (env[c][0].flags | 8'h01) & 8'hFB;
                  rewind(c, 1);
                  env[c][1].flags = (env[c][1].flags | 8'h01) & 8'hFB;
                  vol = run_envelope(c, 0, 0);
                  per = run_envelope(c, 1, nper[c]);
                  return;
               end
            end
         end
         chflags[c][6] = 1;
      endfunction

      function void write_reg(logic [1:0] idx, logic [16:0] data);
         case (idx)
            CSR_REPEAT_COUNT:     rep_cfg = data[8] ? int'(data[8:0]) - 512 : int'(data[8:0]);
            CSR_INSTRUMENT_COUNT: inst_cfg = data[5:0];
            CSR_SONG_LENGTH:      len_cfg = data;
            default: ;
         endcase
      endfunction

      // Note an accepted request and queue the results it causes
      function void note_request(req_type r);
         rsp_type o [4];
         int sub, vol, per;
         int sums [8];
         bit err, done;
         case (r.action)
            ACT_WRITE: mem[r.address] = r.song_byte;
            ACT_START: begin
               sub = rd16(0);
               err = len_cfg < 20;
               sums[HB_SUB] = sub;
               sums[HB_VOL] = sub + rd16(sub + 2);
               sums[HB_PER] = sub + rd16(sub + 4);
               for (int c = 0; c < 4; c++) sums[HB_CHN + c] = sub + rd16(sub + 6 + 2 * c);
               sums[HB_BLK] = sub + 16;
               for (int k = 0; k < 8; k++) begin
                  if (sums[k] > len_cfg) err = 1;
                  hb[k] = 16'(sums[k]);
               end
               spd_reload = 16'(rd16(sub));
               rep_left = rep_cfg;
               pend = NO_SAMPLE;
               restart();
               stopped = err;
               o[0] = '0;
               o[0].song_ended = stopped;
               o[0].header_error = err;
               o[0].last = 1;
               expected.push_back(o[0]);
            end
            ACT_TICK: begin
               if (stopped) begin
                  for (int c = 0; c < 4; c++) begin
                     o[c] = '0;
                     o[c].channel = 2'(c);
                     o[c].song_ended = 1;
                     o[c].last = (c == 3);
                  end
               end else begin
                  spd_cnt--;
                  pend = NO_SAMPLE;
                  for (int c = 0; c < 4; c++) begin
                     voice_step(c, vol, per);
                     o[c] = '0;
                     o[c].channel = 2'(c);
                     o[c].volume = 15'(vol);
                     o[c].period = 15'(per);
                     if (pend != NO_SAMPLE && pend < inst_cfg) begin
                        o[c].sample_load = 1;
                        o[c].sample_index = 5'(pend);
                        pend = NO_SAMPLE;
                     end
                     o[c].last = (c == 3);
                  end
                  if (spd_cnt == 0) spd_cnt = spd_reload;
                  done = 1;
                  for (int c = 0; c < 4; c++) if (!chflags[c][6]) done = 0;
                  // Song end: restart, count down repeats or stop
                  if (done) begin
                     if (rep_left > 0) begin
                        rep_left--;
                        restart();
                     end else if (rep_left != -1) begin
                        stopped = 1;
                     end else begin
                        restart();
                     end
                  end
                  for (int c = 0; c < 4; c++) o[c].song_ended = stopped;
               end
               for (int c = 0; c < 4; c++) expected.push_back(o[c]);
            end
            default: ;
         endcase
      endfunction

      // Compare a result with the oldest expectation; empty string when it matches
      function string check_result(rsp_type got);
         rsp_type w;
         string m;
         if (expected.size() == 0) return $sformatf("result with nothing pending: %h", got);
         w = expected.pop_front();
         m = "";
         if (got.channel !== w.channel)
            m = {m, $sformatf(" channel %0d want %0d", got.channel, w.channel)};
         if (got.volume !== w.volume)
            m = {m, $sformatf(" volume %0d want %0d", got.volume, w.volume)};
         if (got.period !== w.period)
            m = {m, $sformatf(" period %0d want %0d", got.period, w.period)};
         if (got.sample_load !== w.sample_load)
            m = {m, $sformatf(" sample_load %0b want %0b", got.sample_load, w.sample_load)};
         if (got.sample_index !== w.sample_index)
            m = {m, $sformatf(" sample_index %0d want %0d", got.sample_index, w.sample_index)};
         if (got.song_ended !== w.song_ended)
            m = {m, $sformatf(" song_ended %0b want %0b", got.song_ended, w.song_ended)};
         if (got.header_error !== w.header_error)
            m = {m, $sformatf(" header_error %0b want %0b", got.header_error, w.header_error)};
         if (got.last !== w.last)
            m = {m, $sformatf(" last %0b want %0b", got.last, w.last)};
         if (m != "") m = {$sformatf("voice %0d:", w.channel), m};
         return m;
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [16:0] csr_wdata;

   sequencer_scoreboard sb;
   bit [7:0] song_img [IMG_BYTES];
   int errors;
   int idle_pct, stall_pct;
   int hold_req, hold_seen, hold_left;
   int quiet_cycles;
   int played;

   tracker_music_sequencer dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   task automatic report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   // Check every accepted request and result, note register writes
   always @(posedge clock) begin
      string m;
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (rsp_valid && !rsp_stall) begin
            m = sb.check_result(rsp_data);
            if (m != "") report(m);
         end
      end
   end

   // Receiver: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WDOG_LIMIT) begin
         $display("watchdog expired at %0t", $time);
         $display("tracker_music_sequencer verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request and hold it until taken, then maybe idle
   task automatic send(logic [1:0] act, logic [15:0] addr, logic [7:0] data);
      req_type r;
      r.action = act;
      r.address = addr;
      r.song_byte = data;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic tick();
      send(ACT_TICK, 16'($urandom), 8'($urandom));
      played++;
   endtask

   task automatic start();
      send(ACT_START, 16'($urandom), 8'($urandom));
      played++;
   endtask

   // Drop valid and wait until every expected result has come
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [16:0] data);
      drain();
      repeat (50) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_repeat(int n);
      write_reg(CSR_REPEAT_COUNT, {8'($urandom), 9'(n)});
   endtask

   // Song generator: all pointers stay inside the loaded image
   task automatic gen_header(bit runaway);
      song_img[0] = 0;
      song_img[1] = SUB_AT;
      song_img[2] = 0;
      song_img[3] = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
      song_img[4] = 0;
      song_img[5] = SLIDES_AT - SUB_AT;
      song_img[6] = 0;
      song_img[7] = SLIDES_AT + 52 - SUB_AT;
      for (int c = 0; c < 4; c++) begin
         song_img[8 + 2 * c] = 0;
         song_img[9 + 2 * c] = TRACKS_AT + 5 * c - SUB_AT;
      end
      if (runaway) song_img[15] = RUNAWAY_AT - SUB_AT;
      song_img[16] = 8'($urandom);
      song_img[17] = 8'($urandom);
      for (int b = 0; b < 5; b++) begin
         song_img[BLKTAB_AT + 2 * b] = 0;
         song_img[BLKTAB_AT + 2 * b + 1] =
            (b < 4) ? 8'(BLOCKS_AT + 20 * b - SUB_AT) : 8'(EMPTY_AT - SUB_AT);
      end
   endtask

   task automatic gen_slides();
      int a;
      for (int e = 0; e < 8; e++) begin
         a = SLIDES_AT + 13 * e;
         song_img[a] = 8'($urandom);
         for (int t = 0; t < 4; t++) begin
            song_img[a + 1 + 3 * t] = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
            song_img[a + 2 + 3 * t] = 8'($urandom);
            song_img[a + 3 + 3 * t] = 8'($urandom_range(1, 4));
         end
      end
   endtask

   task automatic gen_track(int c);
      int a, n;
      a = TRACKS_AT + 5 * c;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(1, 2);
      for (int k = 0; k < 5; k++)
         song_img[a + k] = (k < n) ? 8'($urandom_range(0, 4)) : END_MARK;
   endtask

   task automatic gen_block(int b);
      int a, lim, k;
      a = BLOCKS_AT + 20 * b;
      lim = a + 19;
      song_img[a] = CMD_TICKS |
         8'(($urandom_range(0, 7) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3));
      a++;
      while (a < lim) begin
         k = $urandom_range(0, 10);
         if (k >= 7 && a + 1 >= lim) k = 0;
         case (k)
            0, 1, 2, 3: song_img[a] = ($urandom_range(0, 15) == 0) ? 8'd0 :
                                      8'($urandom_range(1, 127));
            4: song_img[a] = CMD_TICKS | 8'($urandom_range(0, 15));
            5: song_img[a] = CMD_SAMPLE | 8'($urandom_range(0, 31));
            6: song_img[a] = CMD_VOLSLIDE | 8'($urandom_range(0, 3));
            7: begin
               song_img[a] = CMD_GROUP | 8'(EXT_PERMOD);
               a++;
               song_img[a] = 8'($urandom);
            end
            8, 9: begin
               song_img[a] = CMD_GROUP | 8'($urandom_range(EXT_PSLIDE_A, EXT_PSLIDE_B));
               a++;
               song_img[a] = 8'($urandom_range(0, 3));
            end
            default: song_img[a] = 8'($urandom_range(8'hE3, 8'hFE));
         endcase
         a++;
      end
      song_img[lim] = END_MARK;
   endtask

   // Write image bytes that differ from what the sequencer already holds, or all of them when every is set
   task automatic load_song(bit every);
      for (int a = 0; a < IMG_BYTES; a++)
         if (every || song_img[a] != sb.mem[a]) send(ACT_WRITE, 16'(a), song_img[a]);
   endtask

   task automatic noise();
      case ($urandom_range(0, 9))
         0: send(ACT_IGNORED, 16'($urandom), 8'($urandom));
         1: start();
         default: send(ACT_WRITE, 16'($urandom_range(IMG_BYTES, 65535)), 8'($urandom));
      endcase
   endtask

   initial begin
      int rounds;
      int n;
      sb = new();
      errors = 0;
      played = 0;
      idle_pct = 0;
      stall_pct = 0;
      hold_req = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Ticks while stopped, an ignored action, writes to high and alternating-bit addresses, an unused register
      tick();
      tick();
      send(ACT_IGNORED, 16'hFFFF, 8'hFF);
      send(ACT_WRITE, 16'hFFFF, 8'h00);
      send(ACT_WRITE, 16'h8000, 8'hFF);
      send(ACT_WRITE, 16'h5555, 8'hAA);
      send(ACT_WRITE, 16'hAAAA, 8'h55);
      write_reg(CSR_UNUSED, 17'h1FFFF);

      // Build and load the first song
      gen_header(0);
      gen_slides();
      for (int c = 0; c < 4; c++) gen_track(c);
      for (int b = 0; b < 4; b++) gen_block(b);
      song_img[EMPTY_AT] = END_MARK;
      for (int a = EMPTY_AT + 1; a < RUNAWAY_AT; a++) song_img[a] = 8'($urandom);
      for (int a = RUNAWAY_AT; a < IMG_BYTES - 1; a++) song_img[a] = 8'd4;
      song_img[IMG_BYTES - 1] = END_MARK;
      load_song(1);

      // Header errors: short song, offsets past the length, offset overflowing 16 bits
      write_reg(CSR_SONG_LENGTH, 17'd19);
      start();
      tick();
      write_reg(CSR_SONG_LENGTH, 17'd100);
      start();
      write_reg(CSR_SONG_LENGTH, 17'd0);
      start();
      song_img[8] = 8'hFF;
      song_img[9] = 8'hFF;
      load_song(0);
      write_reg(CSR_SONG_LENGTH, 17'h10000);
      start();
      tick();
      song_img[8] = 0;
      song_img[9] = TRACKS_AT - SUB_AT;
      load_song(0);

      // Normal play, then a runaway walk on the last voice
      write_reg(CSR_SONG_LENGTH, 17'h1FFFF);
      write_reg(CSR_INSTRUMENT_COUNT, 17'd32);
      set_repeat(0);
      start();
      repeat (6) tick();
      song_img[15] = RUNAWAY_AT - SUB_AT;
      load_song(0);
      write_reg(CSR_INSTRUMENT_COUNT, 17'd63);
      set_repeat(-256);
      start();
      repeat (3) tick();
      song_img[15] = TRACKS_AT + 15 - SUB_AT;
      load_song(0);

      // Random rounds across the idle and stall phases
      played = 0;
      rounds = 0;
      while (played < TARGET_ITEMS) begin
         case (rounds % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 17; stall_pct = 17; end
         endcase
         case ($urandom_range(0, 6))
            0: set_repeat(-1);
            1: set_repeat(0);
            2: set_repeat(255);
            3: set_repeat(-256);
            4: set_repeat($urandom_range(1, 3));
            5: set_repeat(-2);
            default: ;
         endcase
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
               0: write_reg(CSR_INSTRUMENT_COUNT, 17'd0);
               1: write_reg(CSR_INSTRUMENT_COUNT, 17'd32);
               2: write_reg(CSR_INSTRUMENT_COUNT, 17'd63);
               default: write_reg(CSR_INSTRUMENT_COUNT, 17'($urandom_range(0, 63)));
            endcase
         end
         if ($urandom_range(0, 7) == 0)
            write_reg(CSR_SONG_LENGTH, 17'($urandom_range(0, 17'h1FFFF)));
         else
            write_reg(CSR_SONG_LENGTH, 17'(IMG_BYTES));

         // Reshape part of the song and load the changes
         if ($urandom_range(0, 2) == 0 || rounds == 0) gen_header($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 2) == 0) gen_slides();
         for (int c = 0; c < 4; c++) if ($urandom_range(0, 1) == 0) gen_track(c);
         for (int b = 0; b < 4; b++) if ($urandom_range(0, 2) == 0) gen_block(b);
         load_song(0);
         start();

         if (rounds == 2) hold_req <= hold_req + 1;
         n = $urandom_range(20, 40);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) noise();
            tick();
            if (rounds == 3 && k == n / 2) drain();
         end
         rounds++;
      end

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tracker_music_sequencer verification clean");
      end else begin
         $display("tracker_music_sequencer verification failed");
      end
      $finish;
   end

endmodule
